>>> hw/rtl/pvkc_pkg.sv
`timescale 1ns / 1ps

package pvkc_pkg;

    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_TOUCH = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic [9:0] CODE_VOLDOWN = 10'd114;
    localparam logic [9:0] CODE_VOLUP   = 10'd115;
    localparam logic [9:0] CODE_POWER   = 10'd116;
    localparam logic [9:0] CODE_BACK    = 10'd158;

    localparam logic [31:0] KEY_RELEASE = 32'd0;
    localparam logic [31:0] KEY_PRESS   = 32'd1;

    localparam logic [2:0] ACT_NONE       = 3'd0;
    localparam logic [2:0] ACT_SUSPEND    = 3'd1;
    localparam logic [2:0] ACT_WAKE       = 3'd2;
    localparam logic [2:0] ACT_VOLUME     = 3'd3;
    localparam logic [2:0] ACT_SCREENSHOT = 3'd4;
    localparam logic [2:0] ACT_POWER_MENU = 3'd5;
    localparam logic [2:0] ACT_BACK       = 3'd6;
    localparam logic [2:0] ACT_POINTER    = 3'd7;

    localparam logic [1:0] REG_LONG_PRESS  = 2'd0;
    localparam logic [1:0] REG_VOLUME_STEP = 2'd1;

    localparam logic [15:0] LONG_PRESS_RESET  = 16'd2000;
    localparam logic [6:0]  VOLUME_STEP_RESET = 7'd5;
    localparam logic [6:0]  VOLUME_RESET      = 7'd30;
    localparam logic [7:0]  VOLUME_MAX        = 8'd100;

    typedef struct packed {
        logic        display_off;
        logic        power_held;
        logic        voldown_held;
        logic        woke_by_power;
        logic        long_press_seen;
        logic        chord_active;
        logic        voldown_suppressed;
        logic [15:0] held_ms;
        logic [6:0]  volume;
    } ctrl_state_t;

    typedef struct packed {
        logic [2:0]         action;
        logic [6:0]         volume_level;
        logic signed [15:0] pointer_x;
        logic [15:0]        pointer_y;
        logic               pointer_slot;
        logic               pointer_pressed;
        logic               boost_request;
    } result_t;

endpackage

>>> hw/rtl/power_volume_key_chord_controller.sv
`timescale 1ns / 1ps
// An accepted item enters the input register; the update logic then moves it into the result register.
// Throughput: 1 item per cycle while m_ready is high; one pass of update logic between the two.
// A held result stalls only when both the input and result registers are full.
// Reset (aresetn low, synchronous): state cleared, volume 30, long press 2000,
// volume step 5, both pipeline registers empty.

module power_volume_key_chord_controller (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic [9:0]         s_event_code,
    input  logic signed [31:0] s_event_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_action,
    output logic [6:0]         m_volume_level,
    output logic signed [15:0] m_pointer_x,
    output logic [15:0]        m_pointer_y,
    output logic               m_pointer_slot,
    output logic               m_pointer_pressed,
    output logic               m_boost_request,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import pvkc_pkg::*;

    logic               in_valid_reg;
    logic [1:0]         in_kind_reg;
    logic [9:0]         in_code_reg;
    logic signed [31:0] in_value_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    ctrl_state_t        st_reg;
    ctrl_state_t        st_next;
    result_t            res_next;
    logic [15:0]        long_press_reg;
    logic [6:0]         volume_step_reg;
    logic               advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    pvkc_update u_update (
        .st            (st_reg),
        .kind          (in_kind_reg),
        .event_code    (in_code_reg),
        .event_value   (in_value_reg),
        .long_press_ms (long_press_reg),
        .volume_step   (volume_step_reg),
        .st_next       (st_next),
        .res           (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_press_reg  <= LONG_PRESS_RESET;
            volume_step_reg <= VOLUME_STEP_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LONG_PRESS:  long_press_reg  <= cfg_data;
                REG_VOLUME_STEP: volume_step_reg <= cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '{default: '0, volume: VOLUME_RESET};
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg  <= s_kind;
            in_code_reg  <= s_event_code;
            in_value_reg <= s_event_value;
        end
        if (advance) begin
            out_reg <= res_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_action          = out_reg.action;
    assign m_volume_level    = out_reg.volume_level;
    assign m_pointer_x       = out_reg.pointer_x;
    assign m_pointer_y       = out_reg.pointer_y;
    assign m_pointer_slot    = out_reg.pointer_slot;
    assign m_pointer_pressed = out_reg.pointer_pressed;
    assign m_boost_request   = out_reg.boost_request;

endmodule

>>> hw/rtl/pvkc_update.sv
`timescale 1ns / 1ps

module pvkc_update (
    input  pvkc_pkg::ctrl_state_t st,
    input  logic [1:0]            kind,
    input  logic [9:0]            event_code,
    input  logic signed [31:0]    event_value,
    input  logic [15:0]           long_press_ms,
    input  logic [6:0]            volume_step,
    output pvkc_pkg::ctrl_state_t st_next,
    output pvkc_pkg::result_t     res
);
    import pvkc_pkg::*;

    logic        press;
    logic        release_ev;
    logic [7:0]  vol_up_sum;
    logic [6:0]  vol_up;
    logic [6:0]  vol_down;
    logic [15:0] held_inc;

    assign press      = (event_value == KEY_PRESS);
    assign release_ev = (event_value == KEY_RELEASE);
    assign vol_up_sum = {1'b0, st.volume} + {1'b0, volume_step};
    assign vol_up     = (vol_up_sum > VOLUME_MAX) ? VOLUME_MAX[6:0] : vol_up_sum[6:0];
    assign vol_down   = (volume_step >= st.volume) ? 7'd0 : (st.volume - volume_step);
    assign held_inc   = (st.held_ms >= long_press_ms) ? long_press_ms : (st.held_ms + 16'd1);

    always_comb begin
        st_next = st;
        res     = '0;
        case (kind)
            KIND_TOUCH: begin
                if (!st.display_off) begin
                    res.action          = ACT_POINTER;
                    res.boost_request   = 1'b1;
                    res.pointer_x       = event_value[31:16];
                    res.pointer_y       = event_value[15:0];
                    res.pointer_slot    = (event_code >= 10'd2);
                    res.pointer_pressed = (event_code == 10'd1) || (event_code == 10'd3);
                end
            end
            KIND_TICK: begin
                if (st.power_held) begin
                    st_next.held_ms = held_inc;
                    if (!st.long_press_seen && !st.chord_active
                        && held_inc >= long_press_ms) begin
                        st_next.long_press_seen = 1'b1;
                        res.action              = ACT_POWER_MENU;
                        res.boost_request       = 1'b1;
                    end
                end
            end
            KIND_KEY: begin
                case (event_code)
                    CODE_POWER: begin
                        if (press) begin
                            st_next.power_held      = 1'b1;
                            st_next.long_press_seen = 1'b0;
                            st_next.held_ms         = '0;
                            st_next.chord_active    = 1'b0;
                            if (st.display_off) begin
                                st_next.woke_by_power = 1'b1;
                                st_next.display_off   = 1'b0;
                                res.action            = ACT_WAKE;
                                res.boost_request     = 1'b1;
                            end else if (st.voldown_held) begin
                                st_next.chord_active       = 1'b1;
                                st_next.voldown_suppressed = 1'b1;
                                res.action                 = ACT_SCREENSHOT;
                            end
                        end else if (release_ev) begin
                            if (!st.display_off && !st.woke_by_power
                                && !st.long_press_seen && !st.chord_active) begin
                                st_next.display_off = 1'b1;
                                res.action          = ACT_SUSPEND;
                            end
                            st_next.power_held      = 1'b0;
                            st_next.long_press_seen = 1'b0;
                            st_next.held_ms         = '0;
                            st_next.woke_by_power   = 1'b0;
                            st_next.chord_active    = 1'b0;
                        end
                    end
                    CODE_VOLDOWN: begin
                        if (press) begin
                            st_next.voldown_held = 1'b1;
                            if (st.power_held && !st.display_off
                                && !st.woke_by_power && !st.chord_active) begin
                                st_next.chord_active       = 1'b1;
                                st_next.voldown_suppressed = 1'b1;
                                res.action                 = ACT_SCREENSHOT;
                            end
                        end else if (release_ev) begin
                            st_next.voldown_held = 1'b0;
                            if (st.voldown_suppressed) begin
                                st_next.voldown_suppressed = 1'b0;
                            end else if (!st.display_off) begin
                                st_next.volume    = vol_down;
                                res.action        = ACT_VOLUME;
                                res.boost_request = 1'b1;
                            end
                        end
                    end
                    CODE_VOLUP: begin
                        if (release_ev && !st.display_off) begin
                            st_next.volume    = vol_up;
                            res.action        = ACT_VOLUME;
                            res.boost_request = 1'b1;
                        end
                    end
                    CODE_BACK: begin
                        if (release_ev && !st.display_off) begin
                            res.action = ACT_BACK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        res.volume_level = st_next.volume;
    end

endmodule
